// ===== rtl/lpg_pkg.sv =====
// Shared types and codes for the line pixel generator.
package lpg_pkg;

   typedef enum logic [1:0] {
      MODE_SHALLOW_RIGHT = 2'd0,
      MODE_STEEP_RIGHT   = 2'd1,
      MODE_STEEP_LEFT    = 2'd2,
      MODE_SHALLOW_LEFT  = 2'd3
   } octant_type;

   typedef enum logic {
      FUNC_LOAD = 1'b0,
      FUNC_STEP = 1'b1
   } func_type;

endpackage

// ===== rtl/line_pixel_generator.sv =====
// A step word passes through the input register and then the result register to its pixel.
// One word per cycle unless a stalled pixel holds a step; a step: two compares, a few adds.
// Load words give no pixel; a step while no line is active gives none.
// Result register with stall backpressure; input accepted while a pixel waits if it drains.
// Reset (synchronous) drops any active line and empties both word registers.
module line_pixel_generator
   import lpg_pkg::*;
#(
   parameter int COORD_BITS = 12,
   parameter int COLOR_BITS = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_func,
   input  logic signed [COORD_BITS-1:0] req_x_start,
   input  logic signed [COORD_BITS-1:0] req_y_start,
   input  logic signed [COORD_BITS-1:0] req_x_end,
   input  logic signed [COORD_BITS-1:0] req_y_end,
   input  logic        [COLOR_BITS-1:0] req_line_color,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [COORD_BITS-1:0] rsp_pixel_x,
   output logic signed [COORD_BITS-1:0] rsp_pixel_y,
   output logic        [COLOR_BITS-1:0] rsp_pixel_color,
   output logic                         rsp_last_pixel
);

   // input word register
   logic                         in_valid_ff, in_valid_in;
   func_type                     in_func_ff;
   logic signed [COORD_BITS-1:0] in_x0_ff, in_y0_ff, in_x1_ff, in_y1_ff;
   logic        [COLOR_BITS-1:0] in_color_ff;

   // line state
   logic                         busy_ff, busy_in;
   octant_type                   mode_ff;
   logic signed [COORD_BITS-1:0] cur_x_ff, cur_y_ff, stop_ff;
   logic signed [COORD_BITS+3:0] decision_ff;
   logic signed [COORD_BITS+1:0] rise_ff, run_ff;
   logic        [COLOR_BITS-1:0] color_ff;

   // result register
   logic                         out_valid_ff, out_valid_in;
   logic signed [COORD_BITS-1:0] pix_x_ff, pix_y_ff;
   logic        [COLOR_BITS-1:0] pix_color_ff;
   logic                         pix_last_ff;

   octant_type                   su_mode;
   logic signed [COORD_BITS-1:0] su_x, su_y, su_stop;
   logic signed [COORD_BITS+3:0] su_decision;
   logic signed [COORD_BITS+1:0] su_rise, su_run;

   logic                         st_last;
   logic signed [COORD_BITS-1:0] st_x, st_y;
   logic signed [COORD_BITS+3:0] st_decision;

   logic req_take, step_fire, load_fire, advance;

   lpg_setup #(.CoordBits(COORD_BITS)) u_setup (
      .x_start       (in_x0_ff),
      .y_start       (in_y0_ff),
      .x_end         (in_x1_ff),
      .y_end         (in_y1_ff),
      .mode          (su_mode),
      .first_x       (su_x),
      .first_y       (su_y),
      .stop_coord    (su_stop),
      .decision      (su_decision),
      .twice_rise    (su_rise),
      .twice_run_neg (su_run)
   );

   lpg_step #(.CoordBits(COORD_BITS)) u_step (
      .mode          (mode_ff),
      .cur_x         (cur_x_ff),
      .cur_y         (cur_y_ff),
      .stop_coord    (stop_ff),
      .decision      (decision_ff),
      .twice_rise    (rise_ff),
      .twice_run_neg (run_ff),
      .last          (st_last),
      .next_x        (st_x),
      .next_y        (st_y),
      .next_decision (st_decision)
   );

   always_comb begin
      step_fire    = in_valid_ff && in_func_ff == FUNC_STEP && busy_ff;
      advance      = in_valid_ff && (!step_fire || !out_valid_ff || !rsp_stall);
      load_fire    = advance && in_func_ff == FUNC_LOAD;
      req_stall    = in_valid_ff && !advance;
      req_take     = req_valid && !req_stall;
      in_valid_in  = req_take || (in_valid_ff && !advance);
      out_valid_in = (advance && step_fire) || (out_valid_ff && rsp_stall);
      busy_in      = busy_ff;
      if (load_fire) begin
         busy_in = 1'b1;
      end else if (advance && step_fire && st_last) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         busy_ff      <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         busy_ff      <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_func_ff  <= func_type'(req_func);
         in_x0_ff    <= req_x_start;
         in_y0_ff    <= req_y_start;
         in_x1_ff    <= req_x_end;
         in_y1_ff    <= req_y_end;
         in_color_ff <= req_line_color;
      end
      if (load_fire) begin
         mode_ff     <= su_mode;
         cur_x_ff    <= su_x;
         cur_y_ff    <= su_y;
         stop_ff     <= su_stop;
         decision_ff <= su_decision;
         rise_ff     <= su_rise;
         run_ff      <= su_run;
         color_ff    <= in_color_ff;
      end else if (advance && step_fire && !st_last) begin
         cur_x_ff    <= st_x;
         cur_y_ff    <= st_y;
         decision_ff <= st_decision;
      end
      if (advance && step_fire) begin
         pix_x_ff     <= cur_x_ff;
         pix_y_ff     <= cur_y_ff;
         pix_color_ff <= color_ff;
         pix_last_ff  <= st_last;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_pixel_x     = pix_x_ff;
   assign rsp_pixel_y     = pix_y_ff;
   assign rsp_pixel_color = pix_color_ff;
   assign rsp_last_pixel  = pix_last_ff;

   a_last_ends_line: assert property (@(posedge clock) disable iff (reset)
      (advance && step_fire && st_last) |=> !busy_ff)
      else $error("line still active after last pixel");

   a_load_starts_line: assert property (@(posedge clock) disable iff (reset)
      load_fire |=> busy_ff)
      else $error("load did not start a line");

   a_result_flags_last: assert property (@(posedge clock) disable iff (reset)
      (advance && step_fire) |=> (rsp_valid && rsp_last_pixel == !busy_ff))
      else $error("last pixel flag disagrees with line state");

   a_shallow_moves_x: assert property (@(posedge clock) disable iff (reset)
      (advance && step_fire && !st_last &&
       (mode_ff == MODE_SHALLOW_RIGHT || mode_ff == MODE_SHALLOW_LEFT))
      |=> cur_x_ff != $past(cur_x_ff))
      else $error("shallow step did not move x");

endmodule

// ===== rtl/lpg_setup.sv =====
// Line setup: octant classification, endpoint swap and decision term init.
module lpg_setup
   import lpg_pkg::*;
#(
   parameter int CoordBits = 12
) (
   input  logic signed [CoordBits-1:0] x_start,
   input  logic signed [CoordBits-1:0] y_start,
   input  logic signed [CoordBits-1:0] x_end,
   input  logic signed [CoordBits-1:0] y_end,
   output octant_type                  mode,
   output logic signed [CoordBits-1:0] first_x,
   output logic signed [CoordBits-1:0] first_y,
   output logic signed [CoordBits-1:0] stop_coord,
   output logic signed [CoordBits+3:0] decision,
   output logic signed [CoordBits+1:0] twice_rise,
   output logic signed [CoordBits+1:0] twice_run_neg
);

   localparam int DiffBits = CoordBits + 1;
   localparam int DecBits  = CoordBits + 4;

   logic signed [DiffBits-1:0] dx, dy, adx, ady, rise, run_neg;
   logic signed [DecBits-1:0]  rise_ext, run_ext;
   logic                       same_sign, opp_sign, swap;
   logic signed [CoordBits-1:0] sx0, sy0, sx1, sy1;

   always_comb begin
      dx = {x_end[CoordBits-1], x_end} - {x_start[CoordBits-1], x_start};
      dy = {y_end[CoordBits-1], y_end} - {y_start[CoordBits-1], y_start};
      adx = dx[DiffBits-1] ? -dx : dx;
      ady = dy[DiffBits-1] ? -dy : dy;
      same_sign = (dx > 0 && dy > 0) || (dx < 0 && dy < 0);
      opp_sign  = (dx > 0 && dy < 0) || (dx < 0 && dy > 0);

      priority if (same_sign && adx >= ady) begin
         mode = MODE_SHALLOW_RIGHT;
         swap = y_end < y_start;
      end else if (same_sign || dx == 0) begin
         mode = MODE_STEEP_RIGHT;
         swap = y_end < y_start;
      end else if (opp_sign && ady >= adx) begin
         mode = MODE_STEEP_LEFT;
         swap = y_end < y_start;
      end else begin
         mode = MODE_SHALLOW_LEFT;
         swap = x_end > x_start;
      end

      sx0 = swap ? x_end : x_start;
      sy0 = swap ? y_end : y_start;
      sx1 = swap ? x_start : x_end;
      sy1 = swap ? y_start : y_end;

      rise    = {sy1[CoordBits-1], sy1} - {sy0[CoordBits-1], sy0};
      run_neg = {sx0[CoordBits-1], sx0} - {sx1[CoordBits-1], sx1};
      twice_rise    = {rise, 1'b0};
      twice_run_neg = {run_neg, 1'b0};
      rise_ext = {{3{rise[DiffBits-1]}}, rise};
      run_ext  = {{3{run_neg[DiffBits-1]}}, run_neg};

      first_x = sx0;
      first_y = sy0;

      unique case (mode)
         MODE_SHALLOW_RIGHT: begin
            decision   = rise_ext + rise_ext + run_ext;
            stop_coord = sx1;
         end
         MODE_STEEP_RIGHT: begin
            decision   = rise_ext + run_ext + run_ext;
            stop_coord = sy1;
         end
         MODE_STEEP_LEFT: begin
            decision   = run_ext + run_ext - rise_ext;
            stop_coord = sy1;
         end
         default: begin
            decision   = run_ext - rise_ext - rise_ext;
            stop_coord = sx1;
         end
      endcase
   end

endmodule

// ===== rtl/lpg_step.sv =====
// One rasterizer step: last-pixel test and next position and decision term.
module lpg_step
   import lpg_pkg::*;
#(
   parameter int CoordBits = 12
) (
   input  octant_type                  mode,
   input  logic signed [CoordBits-1:0] cur_x,
   input  logic signed [CoordBits-1:0] cur_y,
   input  logic signed [CoordBits-1:0] stop_coord,
   input  logic signed [CoordBits+3:0] decision,
   input  logic signed [CoordBits+1:0] twice_rise,
   input  logic signed [CoordBits+1:0] twice_run_neg,
   output logic                        last,
   output logic signed [CoordBits-1:0] next_x,
   output logic signed [CoordBits-1:0] next_y,
   output logic signed [CoordBits+3:0] next_decision
);

   localparam int DecBits = CoordBits + 4;
   localparam logic signed [CoordBits-1:0] One = CoordBits'(1);

   logic signed [DecBits-1:0] tr, tn;
   logic                      pos, neg;

   always_comb begin
      tr  = {{2{twice_rise[CoordBits+1]}}, twice_rise};
      tn  = {{2{twice_run_neg[CoordBits+1]}}, twice_run_neg};
      pos = decision > 0;
      neg = decision < 0;
      next_x = cur_x;
      next_y = cur_y;
      unique case (mode)
         MODE_SHALLOW_RIGHT: begin
            last          = cur_x == stop_coord;
            next_x        = cur_x + One;
            next_y        = pos ? cur_y + One : cur_y;
            next_decision = decision + tr + (pos ? tn : '0);
         end
         MODE_STEEP_RIGHT: begin
            last          = cur_y == stop_coord;
            next_y        = cur_y + One;
            next_x        = neg ? cur_x + One : cur_x;
            next_decision = decision + tn + (neg ? tr : '0);
         end
         MODE_STEEP_LEFT: begin
            last          = cur_y == stop_coord;
            next_y        = cur_y + One;
            next_x        = pos ? cur_x - One : cur_x;
            next_decision = decision + tn - (pos ? tr : '0);
         end
         default: begin
            last          = cur_x == stop_coord;
            next_x        = cur_x - One;
            next_y        = neg ? cur_y + One : cur_y;
            next_decision = decision - tr + (neg ? tn : '0);
         end
      endcase
   end

endmodule

// ===== tb/sv/line_pixel_generator_tb.sv =====
// Self-checking testbench for line_pixel_generator: random lines, pixel-by-pixel prediction.
module line_pixel_generator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lpg_pkg::*;

   localparam int CW          = 12;
   localparam int KW          = 24;
   localparam int RAND_WORDS  = 1400;
   localparam int QUIET_LIMIT = 2000;
   localparam int MAX_PRINTS  = 40;

   typedef struct {
      func_type              func;
      logic signed [CW-1:0]  x_start;
      logic signed [CW-1:0]  y_start;
      logic signed [CW-1:0]  x_end;
      logic signed [CW-1:0]  y_end;
      logic        [KW-1:0]  line_color;
   } req_word_type;

   typedef struct {
      logic signed [CW-1:0]  x;
      logic signed [CW-1:0]  y;
      logic        [KW-1:0]  color;
      logic                  last;
   } pixel_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_func = FUNC_LOAD;
   logic signed [CW-1:0] req_x_start = '0;
   logic signed [CW-1:0] req_y_start = '0;
   logic signed [CW-1:0] req_x_end = '0;
   logic signed [CW-1:0] req_y_end = '0;
   logic        [KW-1:0] req_line_color = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic signed [CW-1:0] rsp_pixel_x;
   logic signed [CW-1:0] rsp_pixel_y;
   logic        [KW-1:0] rsp_pixel_color;
   logic                 rsp_last_pixel;

   line_pixel_generator #(
      .COORD_BITS(CW),
      .COLOR_BITS(KW)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_x_start    (req_x_start),
      .req_y_start    (req_y_start),
      .req_x_end      (req_x_end),
      .req_y_end      (req_y_end),
      .req_line_color (req_line_color),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_x    (rsp_pixel_x),
      .rsp_pixel_y    (rsp_pixel_y),
      .rsp_pixel_color(rsp_pixel_color),
      .rsp_last_pixel (rsp_last_pixel)
   );

   req_word_type  pending_words[$];
   req_word_type  drive_word;
   pixel_type     pixel_q[$];
   int         total_words;
   int         words_sent;
   int         pixels_seen;
   int         lines_loaded;
   int         lines_done;
   int         mismatches;
   int         quiet_cycles;

   // rasterizer state mirror
   int         pos_x;
   int         pos_y;
   int         stop_at;
   int         err_term;
   int         rise2;
   int         run2_neg;
   octant_type walk_mode = MODE_SHALLOW_RIGHT;
   bit         active;
   logic [KW-1:0] color_hold;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int run_phase();
      int p;
      p = (total_words == 0) ? 0 : words_sent * 3 / total_words;
      return (p > 2) ? 2 : p;
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatches < MAX_PRINTS)
         $display("ERROR @%0t: %s", $time, msg);
      mismatches++;
   endtask

   task automatic predict_word(input req_word_type w);
      int x0, y0, x1, y1, dx, dy, adx, ady, a, b, t;
      bit same_sign, opp_sign, swap;
      pixel_type pix;
      if (w.func == FUNC_LOAD) begin
         x0 = int'(w.x_start);
         y0 = int'(w.y_start);
         x1 = int'(w.x_end);
         y1 = int'(w.y_end);
         dx = x1 - x0;
         dy = y1 - y0;
         adx = (dx < 0) ? -dx : dx;
         ady = (dy < 0) ? -dy : dy;
         same_sign = (dx > 0 && dy > 0) || (dx < 0 && dy < 0);
         opp_sign  = (dx > 0 && dy < 0) || (dx < 0 && dy > 0);
         if (same_sign && adx >= ady) begin
            walk_mode = MODE_SHALLOW_RIGHT;
            swap = (y1 < y0);
         end else if (same_sign || dx == 0) begin
            walk_mode = MODE_STEEP_RIGHT;
            swap = (y1 < y0);
         end else if (opp_sign && ady >= adx) begin
            walk_mode = MODE_STEEP_LEFT;
            swap = (y1 < y0);
         end else begin
            walk_mode = MODE_SHALLOW_LEFT;
            swap = (x1 > x0);
         end
         if (swap) begin
            t = x0; x0 = x1; x1 = t;
            t = y0; y0 = y1; y1 = t;
         end
         a = y1 - y0;
         b = x0 - x1;
         rise2 = 2 * a;
         run2_neg = 2 * b;
         pos_x = x0;
         pos_y = y0;
         case (walk_mode)
            MODE_SHALLOW_RIGHT: begin err_term = 2 * a + b; stop_at = x1; end
            MODE_STEEP_RIGHT:   begin err_term = a + 2 * b; stop_at = y1; end
            MODE_STEEP_LEFT:    begin err_term = 2 * b - a; stop_at = y1; end
            default:            begin err_term = b - 2 * a; stop_at = x1; end
         endcase
         color_hold = w.line_color;
         active = 1'b1;
         lines_loaded++;
      end else if (active) begin
         if (walk_mode == MODE_SHALLOW_RIGHT || walk_mode == MODE_SHALLOW_LEFT)
            pix.last = (pos_x == stop_at);
         else
            pix.last = (pos_y == stop_at);
         pix.x = pos_x[CW-1:0];
         pix.y = pos_y[CW-1:0];
         pix.color = color_hold;
         pixel_q.push_back(pix);
         if (pix.last) begin
            active = 1'b0;
            lines_done++;
         end else begin
            case (walk_mode)
               MODE_SHALLOW_RIGHT: begin
                  if (err_term > 0) begin pos_y++; err_term += run2_neg; end
                  pos_x++;
                  err_term += rise2;
               end
               MODE_STEEP_RIGHT: begin
                  if (err_term < 0) begin pos_x++; err_term += rise2; end
                  pos_y++;
                  err_term += run2_neg;
               end
               MODE_STEEP_LEFT: begin
                  if (err_term > 0) begin pos_x--; err_term -= rise2; end
                  pos_y++;
                  err_term += run2_neg;
               end
               default: begin
                  if (err_term < 0) begin pos_y++; err_term += run2_neg; end
                  pos_x--;
                  err_term -= rise2;
               end
            endcase
         end
      end
   endtask

   // step words carry junk payload; the block must ignore it
   function automatic req_word_type step_word();
      req_word_type w;
      w.func       = FUNC_STEP;
      w.x_start    = CW'($urandom_range(0, 4095));
      w.y_start    = CW'($urandom_range(0, 4095));
      w.x_end      = CW'($urandom_range(0, 4095));
      w.y_end      = CW'($urandom_range(0, 4095));
      w.line_color = KW'($urandom_range(0, 24'hFFFFFF));
      return w;
   endfunction

   task automatic add_line(input int x0, input int y0, input int x1, input int y1,
                           input logic [KW-1:0] color, input int steps);
      req_word_type w;
      w.func       = FUNC_LOAD;
      w.x_start    = x0[CW-1:0];
      w.y_start    = y0[CW-1:0];
      w.x_end      = x1[CW-1:0];
      w.y_end      = y1[CW-1:0];
      w.line_color = color;
      pending_words.push_back(w);
      repeat (steps) pending_words.push_back(step_word());
   endtask

   function automatic int rand_coord();
      int v;
      v = $urandom_range(0, 4095);
      return v - 2048;
   endfunction

   function automatic int end_coord(input int s, input int d);
      int e;
      e = s + d;
      if (e > 2047 || e < -2048)
         e = s - d;
      return e;
   endfunction

   // stimulus
   initial begin
      int random_words, ticket, span, dx, dy, x0, y0, x1, y1, n, steps, adx, ady;
      random_words = 0;

      pending_words.push_back(step_word());                   // step with no line
      add_line(2047, -2048, 2047, -2048, 24'hFFFFFF, 2);       // point, then idle step
      add_line(-2048, 2047, -2048, 2044, 24'h000000, 4);       // vertical, drawn upward
      add_line(-3, 0, 0, 0, 24'hA5A5A5, 4);                    // horizontal
      add_line(5, -2, 2, -5, 24'h5A5A5A, 4);                   // diagonal
      add_line(1, 2, -1, 7, 24'h123456, 3);                    // steep left, cut short
      add_line(0, 0, 1, 2, 24'h800001, 3);                     // steep right

      // full-span diagonal, cut short
      add_line(2047, 2047, -2048, -2048, KW'($urandom_range(0, 24'hFFFFFF)), 64);

      while (random_words < RAND_WORDS) begin
         ticket = $urandom_range(0, 99);
         if (ticket < 3) begin
            pending_words.push_back(step_word());
            random_words++;
         end else if (ticket < 5) begin
            add_line(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                     KW'($urandom_range(0, 24'hFFFFFF)), 0);
            random_words++;
         end else begin
            span = (ticket < 12) ? $urandom_range(0, 300) : $urandom_range(0, 12);
            dx = $urandom_range(0, span);
            dy = $urandom_range(0, span);
            if ($urandom_range(0, 1)) dx = -dx;
            if ($urandom_range(0, 1)) dy = -dy;
            case ($urandom_range(0, 9))
               0: dx = 0;
               1: dy = 0;
               2: dy = $urandom_range(0, 1) ? dx : -dx;
               default: ;
            endcase
            x0 = rand_coord();
            y0 = rand_coord();
            x1 = end_coord(x0, dx);
            y1 = end_coord(y0, dy);
            adx = (x1 > x0) ? x1 - x0 : x0 - x1;
            ady = (y1 > y0) ? y1 - y0 : y0 - y1;
            n = ((adx > ady) ? adx : ady) + 1;
            case ($urandom_range(0, 9))
               0: steps = $urandom_range(0, n - 1);
               1: steps = n + $urandom_range(1, 2);
               default: steps = n;
            endcase
            add_line(x0, y0, x1, y1, KW'($urandom_range(0, 24'hFFFFFF)), steps);
            random_words += 1 + steps;
         end
      end

      // full-height steep line, cut short
      add_line(rand_coord(), -2048, rand_coord(), 2047,
               KW'($urandom_range(0, 24'hFFFFFF)), 64);

      total_words = pending_words.size();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0 || req_valid || pixel_q.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Run covered %0d words: %0d line loads, %0d lines drawn to their end,",
               words_sent, lines_loaded, lines_done);
      $display("%0d pixels checked across heavy, swapped and no backpressure phases.",
               pixels_seen);
      if (mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // driver
   always @(posedge clock) begin
      int idle_pct;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_word(drive_word);
            words_sent++;
         end
         if (!req_valid || !req_stall) begin
            case (run_phase())
               0:       idle_pct = 11;
               1:       idle_pct = 77;
               default: idle_pct = 0;
            endcase
            if (pending_words.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
               drive_word = pending_words.pop_front();
               req_valid      <= 1'b1;
               req_func       <= drive_word.func;
               req_x_start    <= drive_word.x_start;
               req_y_start    <= drive_word.y_start;
               req_x_end      <= drive_word.x_end;
               req_y_end      <= drive_word.y_end;
               req_line_color <= drive_word.line_color;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      pixel_type want;
      int stall_pct;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            pixels_seen++;
            if (pixel_q.size() == 0) begin
               report_mismatch($sformatf("pixel (%0d,%0d) with none expected",
                                         rsp_pixel_x, rsp_pixel_y));
            end else begin
               want = pixel_q.pop_front();
               if (rsp_pixel_x !== want.x)
                  report_mismatch($sformatf("pixel %0d x: got %0d want %0d",
                                            pixels_seen, rsp_pixel_x, want.x));
               if (rsp_pixel_y !== want.y)
                  report_mismatch($sformatf("pixel %0d y: got %0d want %0d",
                                            pixels_seen, rsp_pixel_y, want.y));
               if (rsp_pixel_color !== want.color)
                  report_mismatch($sformatf("pixel %0d color: got %h want %h",
                                            pixels_seen, rsp_pixel_color, want.color));
               if (rsp_last_pixel !== want.last)
                  report_mismatch($sformatf("pixel %0d last: got %b want %b",
                                            pixels_seen, rsp_last_pixel, want.last));
            end
         end
         case (run_phase())
            0:       stall_pct = 77;
            1:       stall_pct = 11;
            default: stall_pct = 0;
         endcase
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles", QUIET_LIMIT);
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

endmodule

// ===== line_pixel_generator.f =====
rtl/lpg_pkg.sv
rtl/lpg_setup.sv
rtl/lpg_step.sv
rtl/line_pixel_generator.sv
tb/sv/line_pixel_generator_tb.sv
